### rtl/assert_macros.svh
// assertion macros shared by the reprojection error rtl
// no dependencies; the asserting module supplies clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define BRE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bre assertion failed");
// condition in one cycle implies a result in the next
`define BRE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bre assertion failed");
`else
`define BRE_ASSERT(label, prop)
`define BRE_ASSERT_NEXT(label, pre, post)
`endif
`endif

### rtl/bre_pkg.sv
// types, constants and fixed point helpers for the reprojection error pipeline
// no dependencies
package bre_pkg;

    localparam int DataW = 32;
    localparam int FracW = 16;
    localparam int UnitW = 30;

    localparam int SqrtSteps = 32;
    localparam int QdivSteps = 31;
    localparam int CdivSteps = 32;

    // pipeline positions of each segment in the valid line
    localparam int SqPos = 3;
    localparam int QdPos = SqPos + SqrtSteps + 1;
    localparam int RtPos = QdPos + QdivSteps + 1;
    localparam int CdPos = RtPos + 6;
    localparam int PPos  = CdPos + CdivSteps + 1;
    localparam int Depth = PPos + 13;

    typedef logic signed [DataW-1:0] fix_t;

    localparam fix_t UnitOne = 32'sd1073741824;
    localparam fix_t FixOne  = 32'sd65536;
    localparam fix_t ValMax  = 32'sh7fffffff;
    localparam fix_t ValMin  = 32'sh80000000;
    localparam logic signed [63:0] ValMax64 = 64'sd2147483647;
    localparam logic signed [63:0] ValMin64 = -64'sd2147483648;

    localparam logic [1:0] RegFocal = 2'd0;
    localparam logic [1:0] RegK1    = 2'd1;
    localparam logic [1:0] RegK2    = 2'd2;

    typedef struct packed {
        fix_t sx;
        fix_t sy;
        fix_t sz;
        fix_t px;
        fix_t py;
        fix_t pz;
        fix_t su;
        fix_t sv;
    } geo_t;

    typedef struct packed {
        fix_t su;
        fix_t sv;
        logic deg;
        logic clip;
    } tail_t;

    typedef struct packed {
        fix_t val;
        logic clip;
    } satv_t;

    function automatic logic signed [63:0] mul32(input fix_t a, input fix_t b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic satv_t sat64(input logic signed [63:0] v);
        satv_t r;
        if (v > ValMax64)
        begin
            r.val  = ValMax;
            r.clip = 1'b1;
        end
        else if (v < ValMin64)
        begin
            r.val  = ValMin;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = v[DataW-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // round half up by the fraction width, then saturate
    function automatic satv_t mulq_fin(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (FracW - 1))) >>> FracW;
        return sat64(t);
    endfunction

    // round half up by the unit width
    function automatic logic signed [33:0] rnd_unit(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (UnitW - 1))) >>> UnitW;
        return t[33:0];
    endfunction

    function automatic fix_t clamp_unit(input logic signed [35:0] v);
        if (v > 36'(UnitOne))
            return UnitOne;
        else if (v < -36'(UnitOne))
            return -UnitOne;
        else
            return v[DataW-1:0];
    endfunction

    // quotient magnitude, overflow and sign to a saturated value
    function automatic satv_t quo_sat(input logic [31:0] mq, input logic ovf, input logic neg);
        satv_t r;
        if (ovf || (!neg && mq > 32'h7fffffff) || (neg && mq > 32'h80000000))
        begin
            r.clip = 1'b1;
            r.val  = neg ? ValMin : ValMax;
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = neg ? -$signed(mq) : $signed(mq);
        end
        return r;
    endfunction

endpackage

### rtl/bundle_reprojection_error_top.sv
// reprojection residual pipeline: quaternion normalize, rotate, project, distort
// depends on bre_pkg and assert_macros.svh
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: 12 x 32 bit pose, point, observation
//  m_*      out  m_tvalid/m_tready    m_tdata: error_u, error_v; m_tuser: flags
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data: focal, k1, k2
//
// one item per cycle sustained unless the output is stalled, 120 register stages
// most stages belong to the square root (32 stages, one result bit each) and the two
// restoring dividers (31 and 32 stages, one quotient bit each)
// reset clears the valid line and loads focal 1.0, k1 0, k2 0
// a stalled output freezes every stage at once; nothing is dropped or repeated
// cfg_ready is always high; writes are expected while the pipeline is empty
`include "assert_macros.svh"

module bundle_reprojection_error_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rot_w, rot_x, rot_y, rot_z, shift_x, shift_y, shift_z,
    // point_x, point_y, point_z, seen_u, seen_v (32 bits each, low first)
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // error_u [31:0], error_v [63:32]
    output logic [63:0]  m_tdata,
    // degenerate [0], saturated [1]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int SQ = bre_pkg::SqrtSteps;
    localparam int QD = bre_pkg::QdivSteps;
    localparam int CD = bre_pkg::CdivSteps;

    // pipeline advance: move everything unless the output item is held
    logic adv;
    logic [bre_pkg::Depth-1:0] vld_reg;

    assign adv      = !vld_reg[bre_pkg::Depth-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[bre_pkg::Depth-1];
    assign cfg_ready = 1'b1;

    // configuration registers
    bre_pkg::fix_t focal_reg, k1_reg, k2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg <= bre_pkg::FixOne;
            k1_reg    <= '0;
            k2_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bre_pkg::RegFocal: focal_reg <= cfg_data;
                bre_pkg::RegK1:    k1_reg    <= cfg_data;
                bre_pkg::RegK2:    k2_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid line travels alongside the data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[bre_pkg::Depth-2:0], s_tvalid};
    end

    // ---------------- front: halve, square, sum ----------------
    bre_pkg::fix_t q0_reg [4];
    bre_pkg::geo_t g0_reg;
    bre_pkg::fix_t q1_reg [4];
    bre_pkg::fix_t q1_next [4];
    bre_pkg::geo_t g1_reg;
    logic          z1_reg, z1_next, big;
    bre_pkg::fix_t q2_reg [4];
    logic [60:0]   sqr2_reg [4];
    logic [60:0]   sqr2_next [4];
    bre_pkg::geo_t g2_reg;
    logic          z2_reg;
    logic [62:0]   sum_next;

    always_comb
    begin
        big     = 1'b0;
        z1_next = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (q0_reg[i] >= bre_pkg::UnitOne || q0_reg[i] <= -bre_pkg::UnitOne)
                big = 1'b1;
            if (q0_reg[i] != '0)
                z1_next = 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            q1_next[i]   = big ? (q0_reg[i] >>> 1) : q0_reg[i];
            sqr2_next[i] = 61'(bre_pkg::mul32(q1_reg[i], q1_reg[i]));
        end
        sum_next = 63'(sqr2_reg[0]) + 63'(sqr2_reg[1]) + 63'(sqr2_reg[2]) + 63'(sqr2_reg[3]);
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [62:0]   sq_n_reg [SQ+1];
    logic [63:0]   sq_r_reg [SQ+1];
    bre_pkg::fix_t sq_q_reg [SQ+1][4];
    bre_pkg::geo_t sq_g_reg [SQ+1];
    logic          sq_z_reg [SQ+1];
    logic [62:0]   sq_n_next [SQ];
    logic [63:0]   sq_r_next [SQ];
    logic [63:0]   sq_bit [SQ];
    logic [63:0]   sq_trial [SQ];

    always_comb
    begin
        for (int j = 0; j < SQ; j++)
        begin
            sq_bit[j]   = 64'd1 << (2 * (SQ - 1 - j));
            sq_trial[j] = sq_r_reg[j] + sq_bit[j];
            if ({1'b0, sq_n_reg[j]} >= sq_trial[j])
            begin
                sq_n_next[j] = sq_n_reg[j] - sq_trial[j][62:0];
                sq_r_next[j] = (sq_r_reg[j] >> 1) + sq_bit[j];
            end
            else
            begin
                sq_n_next[j] = sq_n_reg[j];
                sq_r_next[j] = sq_r_reg[j] >> 1;
            end
        end
    end

    // ---------------- quaternion / norm, one quotient bit per stage ----------------
    logic [60:0]   qd_rem_reg [QD+1][4];
    logic [30:0]   qd_quo_reg [QD+1][4];
    logic [3:0]    qd_neg_reg [QD+1];
    logic [31:0]   qd_norm_reg [QD+1];
    bre_pkg::geo_t qd_g_reg [QD+1];
    logic          qd_z_reg [QD+1];
    logic [60:0]   qd_rem_next [QD+1][4];
    logic [30:0]   qd_quo_next [QD][4];
    logic [31:0]   qd_mag [4];
    logic [63:0]   qd_dv [QD];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qd_mag[i] = sq_q_reg[SQ][i][31] ? 32'(-sq_q_reg[SQ][i]) : sq_q_reg[SQ][i];
            qd_rem_next[QD][i] = 61'(qd_mag[i][30:0]) << bre_pkg::UnitW;
        end
        for (int k = 0; k < QD; k++)
        begin
            qd_dv[k] = 64'(qd_norm_reg[k]) << (QD - 1 - k);
            for (int i = 0; i < 4; i++)
            begin
                qd_quo_next[k][i] = qd_quo_reg[k][i];
                if (64'(qd_rem_reg[k][i]) >= qd_dv[k])
                begin
                    qd_rem_next[k][i] = qd_rem_reg[k][i] - qd_dv[k][60:0];
                    qd_quo_next[k][i][QD - 1 - k] = 1'b1;
                end
                else
                    qd_rem_next[k][i] = qd_rem_reg[k][i];
            end
        end
    end

    // ---------------- rotation matrix and camera point ----------------
    bre_pkg::fix_t      u_reg [4];
    bre_pkg::fix_t      u_next [4];
    logic signed [63:0] prod_reg [9];
    bre_pkg::fix_t      rm_reg [9];
    bre_pkg::fix_t      rm_next [9];
    logic signed [63:0] rp_reg [9];
    logic signed [63:0] acc_reg [3];
    bre_pkg::geo_t      rg_reg [5];
    logic               rz_reg [5];
    bre_pkg::fix_t      cam_reg [3];
    bre_pkg::tail_t     t5_reg;
    bre_pkg::satv_t     cam_s [3];
    logic signed [33:0] t2, t3, t4, t5, t6, t7, t8, t9, t1;
    bre_pkg::fix_t      pt_sel [3];
    bre_pkg::fix_t      tr_sel [3];
    logic signed [35:0] one36;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            u_next[i] = qd_neg_reg[QD][i] ? -$signed({1'b0, qd_quo_reg[QD][i]})
                                          : $signed({1'b0, qd_quo_reg[QD][i]});
        one36 = 36'(bre_pkg::UnitOne);
        t2 = bre_pkg::rnd_unit(prod_reg[0]);
        t3 = bre_pkg::rnd_unit(prod_reg[1]);
        t4 = bre_pkg::rnd_unit(prod_reg[2]);
        t5 = -bre_pkg::rnd_unit(prod_reg[3]);
        t6 = bre_pkg::rnd_unit(prod_reg[4]);
        t7 = bre_pkg::rnd_unit(prod_reg[5]);
        t8 = -bre_pkg::rnd_unit(prod_reg[6]);
        t9 = bre_pkg::rnd_unit(prod_reg[7]);
        t1 = -bre_pkg::rnd_unit(prod_reg[8]);
        rm_next[0] = bre_pkg::clamp_unit(one36 + ((36'(t8) + 36'(t1)) <<< 1));
        rm_next[1] = bre_pkg::clamp_unit((36'(t6) - 36'(t4)) <<< 1);
        rm_next[2] = bre_pkg::clamp_unit((36'(t3) + 36'(t7)) <<< 1);
        rm_next[3] = bre_pkg::clamp_unit((36'(t4) + 36'(t6)) <<< 1);
        rm_next[4] = bre_pkg::clamp_unit(one36 + ((36'(t5) + 36'(t1)) <<< 1));
        rm_next[5] = bre_pkg::clamp_unit((36'(t9) - 36'(t2)) <<< 1);
        rm_next[6] = bre_pkg::clamp_unit((36'(t7) - 36'(t3)) <<< 1);
        rm_next[7] = bre_pkg::clamp_unit((36'(t2) + 36'(t9)) <<< 1);
        rm_next[8] = bre_pkg::clamp_unit(one36 + ((36'(t5) + 36'(t8)) <<< 1));
        pt_sel[0] = rg_reg[2].px;
        pt_sel[1] = rg_reg[2].py;
        pt_sel[2] = rg_reg[2].pz;
        tr_sel[0] = rg_reg[4].sx;
        tr_sel[1] = rg_reg[4].sy;
        tr_sel[2] = rg_reg[4].sz;
        for (int i = 0; i < 3; i++)
            cam_s[i] = bre_pkg::sat64(((acc_reg[i] + (64'sd1 <<< (bre_pkg::UnitW - 1)))
                                       >>> bre_pkg::UnitW) + 64'(tr_sel[i]));
    end

    // ---------------- projection divide, one quotient bit per stage ----------------
    logic [47:0]    cd_rem_reg [CD+1][2];
    logic [31:0]    cd_quo_reg [CD+1][2];
    logic [1:0]     cd_ovf_reg [CD+1];
    logic [1:0]     cd_neg_reg [CD+1];
    logic [31:0]    cd_div_reg [CD+1];
    bre_pkg::tail_t cd_t_reg [CD+1];
    logic [47:0]    cd_rem_next [CD+1][2];
    logic [31:0]    cd_quo_next [CD][2];
    logic [31:0]    cd_mag [3];
    logic [63:0]    cd_dv [CD];
    logic [1:0]     cd_ovf_next;
    logic [1:0]     cd_neg_next;
    bre_pkg::tail_t cd_t_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cd_mag[i] = cam_reg[i][31] ? 32'(-cam_reg[i]) : cam_reg[i];
        for (int l = 0; l < 2; l++)
        begin
            cd_rem_next[CD][l] = 48'(cd_mag[l]) << bre_pkg::FracW;
            cd_ovf_next[l] = 64'(cd_rem_next[CD][l]) >= (64'(cd_mag[2]) << CD);
            cd_neg_next[l] = (cam_reg[l][31] == cam_reg[2][31]);
        end
        cd_t_next = t5_reg;
        cd_t_next.deg = t5_reg.deg || (cam_reg[2] == '0);
        for (int k = 0; k < CD; k++)
        begin
            cd_dv[k] = 64'(cd_div_reg[k]) << (CD - 1 - k);
            for (int l = 0; l < 2; l++)
            begin
                cd_quo_next[k][l] = cd_quo_reg[k][l];
                if (64'(cd_rem_reg[k][l]) >= cd_dv[k])
                begin
                    cd_rem_next[k][l] = cd_rem_reg[k][l] - cd_dv[k][47:0];
                    cd_quo_next[k][l][CD - 1 - k] = 1'b1;
                end
                else
                    cd_rem_next[k][l] = cd_rem_reg[k][l];
            end
        end
    end

    // ---------------- distortion and residual tail ----------------
    bre_pkg::fix_t      xp_reg [10];
    bre_pkg::fix_t      yp_reg [10];
    bre_pkg::tail_t     pt_reg [12];
    logic signed [63:0] sqx_reg, sqy_reg, kp_reg, dp_reg, fp_reg, pu_reg, pv_reg;
    bre_pkg::fix_t      ax_reg, ay_reg, d1_reg, d2_reg, dist_reg, predu_reg, predv_reg;
    bre_pkg::fix_t      r2_reg [3];
    bre_pkg::fix_t      eu_reg, ev_reg;
    logic               deg_reg, satf_reg;
    bre_pkg::satv_t     xs, ys, ax_s, ay_s, r2_s, kq_s, d1_s, dq_s, d2_s, dist_s;
    bre_pkg::satv_t     pu_s, pv_s, eu_s, ev_s;
    logic               clip_add [12];

    always_comb
    begin
        xs     = bre_pkg::quo_sat(cd_quo_reg[CD][0], cd_ovf_reg[CD][0], cd_neg_reg[CD][0]);
        ys     = bre_pkg::quo_sat(cd_quo_reg[CD][1], cd_ovf_reg[CD][1], cd_neg_reg[CD][1]);
        ax_s   = bre_pkg::mulq_fin(sqx_reg);
        ay_s   = bre_pkg::mulq_fin(sqy_reg);
        r2_s   = bre_pkg::sat64(64'(ax_reg) + 64'(ay_reg));
        kq_s   = bre_pkg::mulq_fin(kp_reg);
        d1_s   = bre_pkg::sat64(64'(kq_s.val) + 64'(k1_reg));
        dq_s   = bre_pkg::mulq_fin(dp_reg);
        d2_s   = bre_pkg::sat64(64'(dq_s.val) + 64'(bre_pkg::FixOne));
        dist_s = bre_pkg::mulq_fin(fp_reg);
        pu_s   = bre_pkg::mulq_fin(pu_reg);
        pv_s   = bre_pkg::mulq_fin(pv_reg);
        eu_s   = bre_pkg::sat64(64'(predu_reg) - 64'(pt_reg[11].su));
        ev_s   = bre_pkg::sat64(64'(predv_reg) - 64'(pt_reg[11].sv));
        for (int k = 0; k < 12; k++)
            clip_add[k] = 1'b0;
        clip_add[2]  = ax_s.clip || ay_s.clip;
        clip_add[3]  = r2_s.clip;
        clip_add[5]  = kq_s.clip || d1_s.clip;
        clip_add[7]  = dq_s.clip || d2_s.clip;
        clip_add[9]  = dist_s.clip;
        clip_add[11] = pu_s.clip || pv_s.clip;
    end

    // ---------------- data registers, all gated by the advance ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // capture
            for (int i = 0; i < 4; i++)
                q0_reg[i] <= s_tdata[32*i +: 32];
            g0_reg.sx <= s_tdata[128 +: 32];
            g0_reg.sy <= s_tdata[160 +: 32];
            g0_reg.sz <= s_tdata[192 +: 32];
            g0_reg.px <= s_tdata[224 +: 32];
            g0_reg.py <= s_tdata[256 +: 32];
            g0_reg.pz <= s_tdata[288 +: 32];
            g0_reg.su <= s_tdata[320 +: 32];
            g0_reg.sv <= s_tdata[352 +: 32];

            // halve and square
            q1_reg <= q1_next;
            g1_reg <= g0_reg;
            z1_reg <= z1_next;
            q2_reg <= q1_reg;
            sqr2_reg <= sqr2_next;
            g2_reg <= g1_reg;
            z2_reg <= z1_reg;

            // square root
            sq_n_reg[0] <= sum_next;
            sq_r_reg[0] <= '0;
            sq_q_reg[0] <= q2_reg;
            sq_g_reg[0] <= g2_reg;
            sq_z_reg[0] <= z2_reg;
            for (int j = 0; j < SQ; j++)
            begin
                sq_n_reg[j+1] <= sq_n_next[j];
                sq_r_reg[j+1] <= sq_r_next[j];
                sq_q_reg[j+1] <= sq_q_reg[j];
                sq_g_reg[j+1] <= sq_g_reg[j];
                sq_z_reg[j+1] <= sq_z_reg[j];
            end

            // normalize
            for (int i = 0; i < 4; i++)
            begin
                qd_rem_reg[0][i] <= qd_rem_next[QD][i];
                qd_quo_reg[0][i] <= '0;
                qd_neg_reg[0][i] <= sq_q_reg[SQ][i][31];
            end
            qd_norm_reg[0] <= sq_r_reg[SQ][31:0];
            qd_g_reg[0] <= sq_g_reg[SQ];
            qd_z_reg[0] <= sq_z_reg[SQ];
            for (int k = 0; k < QD; k++)
            begin
                qd_rem_reg[k+1] <= qd_rem_next[k];
                qd_quo_reg[k+1] <= qd_quo_next[k];
                qd_neg_reg[k+1] <= qd_neg_reg[k];
                qd_norm_reg[k+1] <= qd_norm_reg[k];
                qd_g_reg[k+1] <= qd_g_reg[k];
                qd_z_reg[k+1] <= qd_z_reg[k];
            end

            // rotation
            u_reg <= u_next;
            rg_reg[0] <= qd_g_reg[QD];
            rz_reg[0] <= qd_z_reg[QD];
            prod_reg[0] <= bre_pkg::mul32(u_reg[0], u_reg[1]);
            prod_reg[1] <= bre_pkg::mul32(u_reg[0], u_reg[2]);
            prod_reg[2] <= bre_pkg::mul32(u_reg[0], u_reg[3]);
            prod_reg[3] <= bre_pkg::mul32(u_reg[1], u_reg[1]);
            prod_reg[4] <= bre_pkg::mul32(u_reg[1], u_reg[2]);
            prod_reg[5] <= bre_pkg::mul32(u_reg[1], u_reg[3]);
            prod_reg[6] <= bre_pkg::mul32(u_reg[2], u_reg[2]);
            prod_reg[7] <= bre_pkg::mul32(u_reg[2], u_reg[3]);
            prod_reg[8] <= bre_pkg::mul32(u_reg[3], u_reg[3]);
            rm_reg <= rm_next;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    rp_reg[3*i + j] <= bre_pkg::mul32(rm_reg[3*i + j], pt_sel[j]);
                acc_reg[i] <= rp_reg[3*i] + rp_reg[3*i + 1] + rp_reg[3*i + 2];
                cam_reg[i] <= cam_s[i].val;
            end
            for (int r = 0; r < 4; r++)
            begin
                rg_reg[r+1] <= rg_reg[r];
                rz_reg[r+1] <= rz_reg[r];
            end
            t5_reg.su   <= rg_reg[4].su;
            t5_reg.sv   <= rg_reg[4].sv;
            t5_reg.deg  <= rz_reg[4];
            t5_reg.clip <= cam_s[0].clip || cam_s[1].clip || cam_s[2].clip;

            // projection divide
            for (int l = 0; l < 2; l++)
            begin
                cd_rem_reg[0][l] <= cd_rem_next[CD][l];
                cd_quo_reg[0][l] <= '0;
            end
            cd_ovf_reg[0] <= cd_ovf_next;
            cd_neg_reg[0] <= cd_neg_next;
            cd_div_reg[0] <= cd_mag[2];
            cd_t_reg[0]   <= cd_t_next;
            for (int k = 0; k < CD; k++)
            begin
                cd_rem_reg[k+1] <= cd_rem_next[k];
                cd_quo_reg[k+1] <= cd_quo_next[k];
                cd_ovf_reg[k+1] <= cd_ovf_reg[k];
                cd_neg_reg[k+1] <= cd_neg_reg[k];
                cd_div_reg[k+1] <= cd_div_reg[k];
                cd_t_reg[k+1]   <= cd_t_reg[k];
            end

            // distortion tail
            xp_reg[0] <= xs.val;
            yp_reg[0] <= ys.val;
            pt_reg[0].su   <= cd_t_reg[CD].su;
            pt_reg[0].sv   <= cd_t_reg[CD].sv;
            pt_reg[0].deg  <= cd_t_reg[CD].deg;
            pt_reg[0].clip <= cd_t_reg[CD].clip || xs.clip || ys.clip;
            for (int k = 1; k < 10; k++)
            begin
                xp_reg[k] <= xp_reg[k-1];
                yp_reg[k] <= yp_reg[k-1];
            end
            for (int k = 1; k < 12; k++)
            begin
                pt_reg[k].su   <= pt_reg[k-1].su;
                pt_reg[k].sv   <= pt_reg[k-1].sv;
                pt_reg[k].deg  <= pt_reg[k-1].deg;
                pt_reg[k].clip <= pt_reg[k-1].clip || clip_add[k];
            end
            sqx_reg   <= bre_pkg::mul32(xp_reg[0], xp_reg[0]);
            sqy_reg   <= bre_pkg::mul32(yp_reg[0], yp_reg[0]);
            ax_reg    <= ax_s.val;
            ay_reg    <= ay_s.val;
            r2_reg[0] <= r2_s.val;
            kp_reg    <= bre_pkg::mul32(k2_reg, r2_reg[0]);
            r2_reg[1] <= r2_reg[0];
            d1_reg    <= d1_s.val;
            r2_reg[2] <= r2_reg[1];
            dp_reg    <= bre_pkg::mul32(r2_reg[2], d1_reg);
            d2_reg    <= d2_s.val;
            fp_reg    <= bre_pkg::mul32(focal_reg, d2_reg);
            dist_reg  <= dist_s.val;
            pu_reg    <= bre_pkg::mul32(dist_reg, xp_reg[9]);
            pv_reg    <= bre_pkg::mul32(dist_reg, yp_reg[9]);
            predu_reg <= pu_s.val;
            predv_reg <= pv_s.val;

            // output register, degenerate items give zero residuals
            if (pt_reg[11].deg)
            begin
                eu_reg   <= '0;
                ev_reg   <= '0;
                satf_reg <= 1'b0;
            end
            else
            begin
                eu_reg   <= eu_s.val;
                ev_reg   <= ev_s.val;
                satf_reg <= pt_reg[11].clip || eu_s.clip || ev_s.clip;
            end
            deg_reg <= pt_reg[11].deg;
        end
    end

    assign m_tdata = {ev_reg, eu_reg};
    assign m_tuser = {satf_reg, deg_reg};

    // ---------------- checks ----------------
    `BRE_ASSERT(a_deg_zero, m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
    `BRE_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_reg))
    `BRE_ASSERT(a_norm_nonzero, vld_reg[bre_pkg::QdPos-1] && !sq_z_reg[SQ] |-> sq_r_reg[SQ] != 64'd0)
    `BRE_ASSERT(a_unit_range, vld_reg[bre_pkg::RtPos-1] && !qd_z_reg[QD] |-> qd_quo_reg[QD][0] <= 31'h40000000 && qd_quo_reg[QD][3] <= 31'h40000000)

endmodule

### tb/bundle_reprojection_error_top_tb.sv
// testbench for the reprojection residual pipeline: directed, random and back-pressure tests
// checks every result against a cycle-free fixed point predictor of the pipeline
// depends on bre_pkg and bundle_reprojection_error_top
module bundle_reprojection_error_top_tb;

    localparam int Latency = 120;
    localparam longint OneQ = 64'sd65536;
    localparam longint OneU = 64'sd1073741824;

    typedef struct {
        logic signed [31:0] err_u;
        logic signed [31:0] err_v;
        logic               degen;
        logic               clipped;
    } residual_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // predictor copy of the registers
    longint focal_q;
    longint k1_q;
    longint k2_q;

    residual_t pending_residuals[$];
    int        mismatches;
    int        hold_cycles;     // long receiver hold-off requested by a test
    bit        tx_burst;        // sender offers items back to back

    bundle_reprojection_error_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // fixed point predictor
    // ------------------------------------------------------------------

    function automatic longint clip32(longint v, inout bit c);
        if (v > 64'sd2147483647)
        begin
            c = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            c = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // round half up, arithmetic shift is a floor
    function automatic longint round_down(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b, inout bit c);
        return clip32(round_down(a * b, bre_pkg::FracW), c);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > OneU)
            return OneU;
        if (v < -OneU)
            return -OneU;
        return v;
    endfunction

    function automatic residual_t predict_residual(logic [383:0] d);
        residual_t        r;
        longint           q[4];
        longint           pt[3];
        longint           tr[3];
        longint           nq[4];
        longint           cam[3];
        longint           rm[3][3];
        longint           maxm;
        longint           norm;
        longint           acc;
        longint           xp, yp, r2, gain, pu, pv;
        longint           t1, t2, t3, t4, t5, t6, t7, t8, t9;
        longint unsigned  sumsq;
        bit               c;
        r.err_u = '0;
        r.err_v = '0;
        r.degen = 1'b1;
        r.clipped = 1'b0;
        c = 1'b0;
        maxm = 0;
        sumsq = 0;
        for (int i = 0; i < 4; i++)
            q[i] = longint'($signed(d[32*i +: 32]));
        for (int i = 0; i < 3; i++)
        begin
            tr[i] = longint'($signed(d[32*(4+i) +: 32]));
            pt[i] = longint'($signed(d[32*(7+i) +: 32]));
        end
        for (int i = 0; i < 4; i++)
            if ((q[i] < 0 ? -q[i] : q[i]) > maxm)
                maxm = q[i] < 0 ? -q[i] : q[i];
        // all-zero quaternion
        if (maxm == 0)
            return r;
        // large quaternion: halve so the squares fit
        if (maxm >= OneU)
            for (int i = 0; i < 4; i++)
                q[i] = q[i] >>> 1;
        for (int i = 0; i < 4; i++)
            sumsq += longint'(q[i] * q[i]);
        norm = longint'(floor_sqrt(sumsq));
        if (norm == 0)
            return r;
        for (int i = 0; i < 4; i++)
            nq[i] = (q[i] * OneU) / norm;

        t2 = round_down(nq[0] * nq[1], bre_pkg::UnitW);
        t3 = round_down(nq[0] * nq[2], bre_pkg::UnitW);
        t4 = round_down(nq[0] * nq[3], bre_pkg::UnitW);
        t5 = -round_down(nq[1] * nq[1], bre_pkg::UnitW);
        t6 = round_down(nq[1] * nq[2], bre_pkg::UnitW);
        t7 = round_down(nq[1] * nq[3], bre_pkg::UnitW);
        t8 = -round_down(nq[2] * nq[2], bre_pkg::UnitW);
        t9 = round_down(nq[2] * nq[3], bre_pkg::UnitW);
        t1 = -round_down(nq[3] * nq[3], bre_pkg::UnitW);
        rm[0][0] = OneU + 2 * (t8 + t1);
        rm[0][1] = 2 * (t6 - t4);
        rm[0][2] = 2 * (t3 + t7);
        rm[1][0] = 2 * (t4 + t6);
        rm[1][1] = OneU + 2 * (t5 + t1);
        rm[1][2] = 2 * (t9 - t2);
        rm[2][0] = 2 * (t7 - t3);
        rm[2][1] = 2 * (t2 + t9);
        rm[2][2] = OneU + 2 * (t5 + t8);

        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += unit_clamp(rm[i][j]) * pt[j];
            cam[i] = clip32(round_down(acc, bre_pkg::UnitW) + tr[i], c);
        end
        // zero depth
        if (cam[2] == 0)
            return r;

        xp = clip32((-cam[0] * OneQ) / cam[2], c);
        yp = clip32((-cam[1] * OneQ) / cam[2], c);
        r2 = clip32(qmul(xp, xp, c) + qmul(yp, yp, c), c);
        gain = clip32(k1_q + qmul(k2_q, r2, c), c);
        gain = clip32(OneQ + qmul(r2, gain, c), c);
        gain = qmul(focal_q, gain, c);
        pu = qmul(gain, xp, c);
        pv = qmul(gain, yp, c);
        r.err_u = 32'(clip32(pu - longint'($signed(d[320 +: 32])), c));
        r.err_v = 32'(clip32(pv - longint'($signed(d[352 +: 32])), c));
        r.degen = 1'b0;
        r.clipped = c;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // sends one item and queues its expected residual on acceptance
    task automatic send_item(input logic [383:0] d);
        int gap;
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_residuals.push_back(predict_residual(d));
        gap = tx_burst ? 0 : ($urandom_range(0, 2) == 0 ? short_or_long_gap() : 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bre_pkg::RegFocal: focal_q = longint'($signed(val));
            bre_pkg::RegK1:    k1_q = longint'($signed(val));
            bre_pkg::RegK2:    k2_q = longint'($signed(val));
            default:  ;
        endcase
    endtask

    // waits until the pipeline has emptied
    task automatic drain();
        while (pending_residuals.size() != 0)
            @(posedge clk);
        repeat (Latency + 10) @(posedge clk);
    endtask

    task automatic set_lens(input logic [31:0] f, input logic [31:0] a, input logic [31:0] b);
        drain();
        write_reg(bre_pkg::RegFocal, f);
        write_reg(bre_pkg::RegK1, a);
        write_reg(bre_pkg::RegK2, b);
    endtask

    function automatic logic [31:0] spread(int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [383:0] pack_item(logic [31:0] w, logic [31:0] x, logic [31:0] y,
        logic [31:0] z, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] px,
        logic [31:0] py, logic [31:0] pz, logic [31:0] su, logic [31:0] sv);
        return {sv, su, pz, py, px, sz, sy, sx, z, y, x, w};
    endfunction

    // mostly plausible poses, some raw bit patterns, a few degenerate cases
    function automatic logic [383:0] random_item();
        logic [383:0] d;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            for (int i = 0; i < 12; i++)
                d[32*i +: 32] = $urandom;
            return d;
        end
        for (int i = 0; i < 4; i++)
            d[32*i +: 32] = spread(2 << 16);
        for (int i = 4; i < 10; i++)
            d[32*i +: 32] = spread(50 << 16);
        d[32*6 +: 32] = spread(20 << 16) + (40 << 16);
        d[320 +: 32] = spread(4 << 16);
        d[352 +: 32] = spread(4 << 16);
        if (pick < 13)
            d[127:0] = '0;
        else if (pick < 16)
        begin
            d[32*6 +: 32] = '0;
            d[32*7 +: 96] = '0;
        end
        else if (pick < 22)
            d[32*$urandom_range(0, 3) +: 32] = $urandom;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        // identity pose, simple projection
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h50000, 32'h10000, 32'h20000, 0, 0, 0));
        // zero quaternion
        send_item(pack_item(0, 0, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8));
        // zero depth
        send_item(pack_item(32'h10000, 0, 0, 0, 32'h30000, 0, 0, 32'h10000, 0, 0, 0, 0));
        // large quaternion, halved before normalizing
        send_item(pack_item(mx, mn, 32'h40000000, 32'hc0000000, 0, 0, 32'h100000,
            32'h10000, 32'h10000, 32'h10000, 32'h8000, 32'hffff8000));
        // tiny quaternion, non-zero but floor norm
        send_item(pack_item(1, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
        // all fields at the extremes
        send_item(pack_item(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_item(pack_item(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_item(pack_item(mx, mn, mx, mn, mn, mx, mn, mx, mn, mx, mn, mx));
        // tiny depth so the divide saturates
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 1, 32'h640000, 32'h640000, 0, 0, 0));
        // negative depth
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'hfffb0000, 32'h10000, 32'hfffe0000,
            0, 32'h1000, 32'h2000));
        // observation at the extremes
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, mx, mn));
        // half-turn about each axis
        send_item(pack_item(0, 32'h10000, 0, 0, 0, 0, 32'hfff60000, 32'h10000, 32'h10000,
            32'h10000, 0, 0));
        send_item(pack_item(0, 0, 32'h10000, 0, 0, 0, 32'hfff60000, 32'h10000, 32'h10000,
            32'h10000, 0, 0));
        send_item(pack_item(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000,
            32'h10000, 0, 0));
        idle_sender();
        // distortion terms, moderate and then at their extremes
        set_lens(32'h01f40000, 32'h00008000, 32'hffffc000);
        send_item(pack_item(32'h10000, 32'h4000, 32'h2000, 32'h1000, 32'h10000, 32'h20000,
            32'h80000, 32'h30000, 32'h10000, 32'h20000, 32'h1000, 32'h2000));
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000,
            0, 0, 0));
        idle_sender();
        set_lens(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h40000, 32'h10000, 32'h10000,
            0, 0, 0));
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h40000, 1, 1, 0, 0, 0));
        idle_sender();
        set_lens(32'h80000000, 32'h7fffffff, 32'h80000000);
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h40000, 32'h10000, 32'h10000,
            0, 0, 0));
        send_item(pack_item(32'h10000, 0, 0, 0, 0, 0, 32'h40000, 0, 0, 0, 32'h10, 32'h20));
        idle_sender();
    endtask

    task automatic test_random();
        logic [31:0] lens[6][3];
        lens = '{
            '{32'h00010000, 32'h00000000, 32'h00000000},
            '{32'h01f40000, 32'hffffe000, 32'h00000400},
            '{32'h00800000, 32'h00010000, 32'h00010000},
            '{32'h7fffffff, 32'h7fffffff, 32'h80000000},
            '{32'h80000000, 32'h80000000, 32'h7fffffff},
            '{32'hfe0c0000, 32'h00000800, 32'hfffff000}
        };
        for (int p = 0; p < 6; p++)
        begin
            // one phase with random lens settings in place of a fixed one
            if (p == 5)
                set_lens($urandom, $urandom, $urandom);
            else
                set_lens(lens[p][0], lens[p][1], lens[p][2]);
            repeat (140) send_item(random_item());
            idle_sender();
        end
    endtask

    // receiver holds off while the sender keeps offering, pipeline fills and stalls
    task automatic test_backpressure();
        drain();
        set_lens(32'h01000000, 32'h00001000, 32'h00000100);
        tx_burst = 1'b1;
        hold_cycles = 400;
        // start offering once the receiver has begun its hold-off
        wait (hold_cycles < 400);
        repeat (200) send_item(random_item());
        tx_burst = 1'b0;
        idle_sender();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls with calm stretches, plus requested hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int run;
        int gap;
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                while (hold_cycles > 0)
                begin
                    @(posedge clk);
                    hold_cycles--;
                end
            end
            run = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = short_or_long_gap();
            if (gap > 0 && hold_cycles == 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        residual_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_residuals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected residual item: %h flags %b", m_tdata, m_tuser);
            end
            else
            begin
                e = pending_residuals.pop_front();
                if (m_tdata[31:0] !== e.err_u || m_tdata[63:32] !== e.err_v
                    || m_tuser[0] !== e.degen || m_tuser[1] !== e.clipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "mismatch: exp u %h v %h deg %b sat %b, got u %h v %h deg %b sat %b",
                            e.err_u, e.err_v, e.degen, e.clipped,
                            m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("bundle_reprojection_error_top_tb failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = bre_pkg::RegFocal;
        cfg_data = '0;
        mismatches = 0;
        hold_cycles = 0;
        tx_burst = 1'b0;
        focal_q = OneQ;
        k1_q = 0;
        k2_q = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();

        while (pending_residuals.size() != 0)
            @(posedge clk);
        repeat (Latency + 10) @(posedge clk);
        if (mismatches == 0)
            $display("bundle_reprojection_error_top_tb passed");
        else
            $display("bundle_reprojection_error_top_tb failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/bre_pkg.sv
rtl/bundle_reprojection_error_top.sv
tb/bundle_reprojection_error_top_tb.sv
